// File: src/bcd_pkg.sv
package bcd_pkg;

    localparam int BUFFERS_DEF    = 32;
    localparam int COUNT_BITS_DEF = 8;

    localparam int OP_W  = 3;
    localparam int DEV_W = 8;
    localparam int BLK_W = 32;
    localparam int IDX_W = 5;
    localparam int ST_W  = 3;

    typedef enum logic [OP_W-1:0] {
        OP_GET     = 3'd0,
        OP_FILL    = 3'd1,
        OP_WRITE   = 3'd2,
        OP_DIRTY   = 3'd3,
        OP_RELEASE = 3'd4,
        OP_PIN     = 3'd5,
        OP_SYNC    = 3'd6,
        OP_NONE    = 3'd7
    } opcode_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 3'd0,
        ST_NO_FREE   = 3'd1,
        ST_BAD_COUNT = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_NO_SYNC   = 3'd4
    } status_t;

endpackage

// File: src/block_cache_directory_lru_unit.sv
// Block buffer cache directory with least-recently-used replacement.
// Command channel: drive opcode, device, block_number and buffer_index with
// start high while busy is low; the word is taken on that edge and busy
// rises on the next cycle until the last result has been shown.
// Result channel: each result word sits on the result ports for one cycle
// with strobe high; last marks the final word of a command. The receiver
// cannot stall, so results are never held back.
// Entry metadata and the recency links live in synchronous memories with a
// registered read; the control walks the entries one at a time, reading
// each entry and then acting on it. A get searches the tags and, on a
// miss, walks the recency list from the oldest entry for a free victim;
// a sync walks the recency list from the newest entry and moves each
// dirty entry of the device with a zero count to the newest end. Fill,
// write, dirty, release and pin act on the entry at buffer_index; a
// release that drops its count to zero also moves it to the newest end.
// One command is in flight at a time. Reset: a clearing pass writes
// every entry and link to its reset value; busy stays high meanwhile.
module block_cache_directory_lru_unit #(
    parameter int BUFFERS    = bcd_pkg::BUFFERS_DEF,
    parameter int COUNT_BITS = bcd_pkg::COUNT_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [bcd_pkg::OP_W-1:0]  opcode,
    input  logic [bcd_pkg::DEV_W-1:0] device,
    input  logic [bcd_pkg::BLK_W-1:0] block_number,
    input  logic [bcd_pkg::IDX_W-1:0] buffer_index,
    output logic                     strobe,
    output logic [bcd_pkg::ST_W-1:0]  status,
    output logic [bcd_pkg::IDX_W-1:0] entry_index,
    output logic                     was_hit,
    output logic                     needs_fill,
    output logic [bcd_pkg::DEV_W-1:0] out_device,
    output logic [bcd_pkg::BLK_W-1:0] out_block,
    output logic                     last
);
    localparam int AW = (BUFFERS > 1) ? $clog2(BUFFERS) : 1;
    localparam int CW = AW + 1;
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
    localparam logic [AW-1:0] LASTE = AW'(BUFFERS - 1);

    typedef enum logic [10:0] {
        S_CLEAR = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_SRD   = 11'b00000000100,
        S_SCHK  = 11'b00000001000,
        S_VRD   = 11'b00000010000,
        S_VCHK  = 11'b00000100000,
        S_ERD   = 11'b00001000000,
        S_EACT  = 11'b00010000000,
        S_MOVE  = 11'b00100000000,
        S_MOVE2 = 11'b01000000000,
        S_FLUSH = 11'b10000000000
    } state_t;

    // Entry memory word: device, block, tagged, valid, dirty, count
    localparam int EW = bcd_pkg::DEV_W + bcd_pkg::BLK_W + 3 + COUNT_BITS;
    logic [EW-1:0]  ent_mem [BUFFERS];
    logic [AW-1:0]  new_mem [BUFFERS];
    logic [AW-1:0]  old_mem [BUFFERS];

    state_t state_reg, state_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] newest_reg, newest_next, oldest_reg, oldest_next;
    logic [bcd_pkg::OP_W-1:0]  op_reg;
    logic [bcd_pkg::DEV_W-1:0] dev_reg;
    logic [bcd_pkg::BLK_W-1:0] blk_reg;
    logic [bcd_pkg::IDX_W-1:0] idx_reg;
    logic any_reg, any_next;
    logic [AW-1:0] nxt_reg, nxt_next;
    logic [AW-1:0] mv_new_reg, mv_old_reg;

    // Memory ports
    logic [AW-1:0] rd_addr;
    logic [EW-1:0] ent_q;
    logic [AW-1:0] new_q, old_q;
    logic          ent_we;
    logic [AW-1:0] ent_wa;
    logic [EW-1:0] ent_wd;
    logic          nw_we, nw2_we, ol_we, ol2_we;
    logic [AW-1:0] nw_wa, nw_wd, nw2_wa, nw2_wd, ol_wa, ol_wd, ol2_wa, ol2_wd;

    // Result
    logic strobe_next, last_next, hit_next, fill_next;
    logic [bcd_pkg::ST_W-1:0]  st_next;
    logic [bcd_pkg::IDX_W-1:0] ei_next;
    logic [bcd_pkg::DEV_W-1:0] od_next;
    logic [bcd_pkg::BLK_W-1:0] ob_next;

    // Decode entry word
    logic [bcd_pkg::DEV_W-1:0] q_dev;
    logic [bcd_pkg::BLK_W-1:0] q_blk;
    logic q_tag, q_val, q_dty;
    logic [COUNT_BITS-1:0] q_cnt;
    assign {q_dev, q_blk, q_tag, q_val, q_dty, q_cnt} = ent_q;

    function automatic logic [EW-1:0] pack_ent(
        input logic [bcd_pkg::DEV_W-1:0] d, input logic [bcd_pkg::BLK_W-1:0] b,
        input logic t, input logic v, input logic y, input logic [COUNT_BITS-1:0] c);
        pack_ent = {d, b, t, v, y, c};
    endfunction

    logic idx_ok;
    assign idx_ok = ({1'b0, idx_reg} < (bcd_pkg::IDX_W + 1)'(BUFFERS));
    assign busy = (state_reg != S_IDLE);

    // Read memories
    always_ff @(posedge clk)
    begin
        ent_q <= ent_mem[rd_addr];
        new_q <= new_mem[rd_addr];
        old_q <= old_mem[rd_addr];
    end

    // Write memories
    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_wa] <= ent_wd;
        end
        if (nw_we)
        begin
            new_mem[nw_wa] <= nw_wd;
        end
        if (nw2_we)
        begin
            new_mem[nw2_wa] <= nw2_wd;
        end
        if (ol_we)
        begin
            old_mem[ol_wa] <= ol_wd;
        end
        if (ol2_we)
        begin
            old_mem[ol2_wa] <= ol2_wd;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        cnt_next    = cnt_reg;
        newest_next = newest_reg;
        oldest_next = oldest_reg;
        any_next    = any_reg;
        nxt_next    = nxt_reg;
        rd_addr     = cur_reg;
        ent_we = 1'b0; ent_wa = cur_reg; ent_wd = ent_q;
        nw_we = 1'b0; nw_wa = cur_reg; nw_wd = cur_reg;
        nw2_we = 1'b0; nw2_wa = cur_reg; nw2_wd = cur_reg;
        ol_we = 1'b0; ol_wa = cur_reg; ol_wd = cur_reg;
        ol2_we = 1'b0; ol2_wa = cur_reg; ol2_wd = cur_reg;
        strobe_next = 1'b0; last_next = 1'b1; hit_next = 1'b0; fill_next = 1'b0;
        st_next = bcd_pkg::ST_OK; ei_next = '0; od_next = '0; ob_next = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                // Sweep every entry to its reset value
                ent_we = 1'b1;
                ent_wd = '0;
                nw_we = 1'b1; nw_wd = (cur_reg == LASTE) ? '0 : cur_reg + 1'b1;
                ol_we = 1'b1; ol_wd = (cur_reg == '0) ? LASTE : cur_reg - 1'b1;
                cur_next = cur_reg + 1'b1;
                if (cur_reg == LASTE)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cnt_next = '0;
                    any_next = 1'b0;
                    unique case (bcd_pkg::opcode_t'(opcode))
                        bcd_pkg::OP_GET:
                        begin
                            cur_next = '0;
                            rd_addr = '0;
                            state_next = S_SRD;
                        end
                        bcd_pkg::OP_SYNC:
                        begin
                            cur_next = newest_reg;
                            rd_addr = newest_reg;
                            state_next = S_SRD;
                        end
                        default:
                        begin
                            cur_next = buffer_index[AW-1:0];
                            rd_addr = buffer_index[AW-1:0];
                            state_next = S_ERD;
                        end
                    endcase
                end
            end
            S_SRD:
            begin
                // Read data arrives next cycle
                state_next = S_SCHK;
            end
            S_SCHK:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (op_reg == bcd_pkg::OP_GET)
                begin
                    if (q_tag && q_dev == dev_reg && q_blk == blk_reg)
                    begin
                        // Hit: bump count unless full
                        strobe_next = 1'b1;
                        ei_next = bcd_pkg::IDX_W'(cur_reg);
                        hit_next = 1'b1;
                        fill_next = !q_val;
                        if (q_cnt >= CMAX)
                        begin
                            st_next = bcd_pkg::ST_OVERFLOW;
                        end
                        else
                        begin
                            ent_we = 1'b1;
                            ent_wd = pack_ent(q_dev, q_blk, q_tag, q_val, q_dty,
                                              q_cnt + 1'b1);
                        end
                        state_next = S_IDLE;
                    end
                    else if (cnt_reg == CW'(BUFFERS - 1))
                    begin
                        cnt_next = '0;
                        cur_next = oldest_reg;
                        rd_addr = oldest_reg;
                        state_next = S_VRD;
                    end
                    else
                    begin
                        cur_next = cur_reg + 1'b1;
                        rd_addr = cur_reg + 1'b1;
                        state_next = S_SRD;
                    end
                end
                else
                begin
                    // Sync walk from newest towards oldest
                    nxt_next = old_q;
                    if (q_dev == dev_reg && q_dty)
                    begin
                        strobe_next = 1'b1;
                        last_next = 1'b0;
                        ei_next = bcd_pkg::IDX_W'(cur_reg);
                        od_next = q_dev;
                        ob_next = q_blk;
                        any_next = 1'b1;
                        ent_we = 1'b1;
                        ent_wd = pack_ent(q_dev, q_blk, q_tag, q_val, 1'b0, q_cnt);
                    end
                    if (q_dev == dev_reg && q_dty && q_cnt == '0 &&
                        cur_reg != newest_reg)
                    begin
                        state_next = S_MOVE;
                    end
                    else if (cnt_reg == CW'(BUFFERS - 1))
                    begin
                        state_next = S_IDLE;
                        if (q_dev == dev_reg && q_dty)
                        begin
                            // Pass through S_FLUSH so the held word goes out first
                            state_next = S_FLUSH;
                        end
                        else
                        begin
                            strobe_next = 1'b1;
                            if (!any_reg)
                            begin
                                st_next = bcd_pkg::ST_NO_SYNC;
                            end
                            else
                            begin
                                // No word of its own; the held word goes out as the final one
                                strobe_next = 1'b0;
                            end
                        end
                    end
                    else
                    begin
                        cur_next = old_q;
                        rd_addr = old_q;
                        state_next = S_SRD;
                    end
                end
            end
            S_VRD:
            begin
                state_next = S_VCHK;
            end
            S_VCHK:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (q_cnt == '0)
                begin
                    ent_we = 1'b1;
                    ent_wd = pack_ent(dev_reg, blk_reg, 1'b1, 1'b0, 1'b0,
                                      COUNT_BITS'(1));
                    strobe_next = 1'b1;
                    ei_next = bcd_pkg::IDX_W'(cur_reg);
                    fill_next = 1'b1;
                    state_next = S_IDLE;
                end
                else if (cnt_reg == CW'(BUFFERS - 1))
                begin
                    strobe_next = 1'b1;
                    st_next = bcd_pkg::ST_NO_FREE;
                    state_next = S_IDLE;
                end
                else
                begin
                    cur_next = new_q;
                    rd_addr = new_q;
                    state_next = S_VRD;
                end
            end
            S_ERD:
            begin
                state_next = S_EACT;
            end
            S_EACT:
            begin
                strobe_next = 1'b1;
                ei_next = idx_reg;
                state_next = S_IDLE;
                if (op_reg == bcd_pkg::OP_NONE)
                begin
                    ei_next = '0;
                end
                else if (!idx_ok)
                begin
                    st_next = bcd_pkg::ST_BAD_COUNT;
                end
                else
                begin
                    ent_we = 1'b1;
                    case (bcd_pkg::opcode_t'(op_reg))
                        bcd_pkg::OP_FILL:
                            ent_wd = pack_ent(q_dev, q_blk, q_tag, 1'b1, q_dty, q_cnt);
                        bcd_pkg::OP_WRITE:
                            ent_wd = pack_ent(q_dev, q_blk, q_tag, 1'b1, 1'b0, q_cnt);
                        bcd_pkg::OP_DIRTY:
                            ent_wd = pack_ent(q_dev, q_blk, q_tag, q_val, 1'b1, q_cnt);
                        bcd_pkg::OP_RELEASE:
                        begin
                            if (q_cnt == '0)
                            begin
                                st_next = bcd_pkg::ST_BAD_COUNT;
                                ent_we = 1'b0;
                            end
                            else
                            begin
                                ent_wd = pack_ent(q_dev, q_blk, q_tag, q_val, q_dty,
                                                  q_cnt - 1'b1);
                                if (q_cnt == COUNT_BITS'(1) && cur_reg != newest_reg)
                                begin
                                    // Hold the word until the move completes
                                    strobe_next = 1'b0;
                                    nxt_next = '0;
                                    state_next = S_MOVE;
                                end
                            end
                        end
                        default:
                        begin
                            if (q_cnt >= CMAX)
                            begin
                                st_next = bcd_pkg::ST_OVERFLOW;
                                ent_we = 1'b0;
                            end
                            else
                            begin
                                ent_wd = pack_ent(q_dev, q_blk, q_tag, q_val, q_dty,
                                                  q_cnt + 1'b1);
                            end
                        end
                    endcase
                end
            end
            S_MOVE:
            begin
                // Unlink cur: links captured in mv_*; relink neighbours
                if (cur_reg == oldest_reg)
                begin
                    oldest_next = mv_new_reg;
                end
                else
                begin
                    nw_we = 1'b1; nw_wa = mv_old_reg; nw_wd = mv_new_reg;
                end
                ol_we = 1'b1; ol_wa = mv_new_reg; ol_wd = mv_old_reg;
                state_next = S_MOVE2;
            end
            S_MOVE2:
            begin
                // Append cur at the newest end
                ol2_we = 1'b1; ol2_wa = cur_reg; ol2_wd = newest_reg;
                nw2_we = 1'b1; nw2_wa = newest_reg; nw2_wd = cur_reg;
                nw_we = 1'b1; nw_wa = cur_reg; nw_wd = cur_reg;
                newest_next = cur_reg;
                if (op_reg == bcd_pkg::OP_RELEASE)
                begin
                    strobe_next = 1'b1;
                    ei_next = idx_reg;
                    state_next = S_IDLE;
                end
                else if (cnt_reg == CW'(BUFFERS))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cur_next = nxt_reg;
                    rd_addr = nxt_reg;
                    state_next = S_SRD;
                end
            end
            S_FLUSH:
            begin
                // Release the held sync word as the final one
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sync results: a dirty hit is emitted with last low; the final word is
    // patched by a lookahead flag below.
    logic pend_reg, pend_next;
    logic [bcd_pkg::ST_W+bcd_pkg::IDX_W+bcd_pkg::DEV_W+bcd_pkg::BLK_W-1:0] pw_reg, pw_next;
    logic pend_go;

    always_comb
    begin
        pend_go = 1'b0;
        pend_next = pend_reg;
        pw_next = pw_reg;
        if (op_reg == bcd_pkg::OP_SYNC && state_reg != S_IDLE)
        begin
            if (strobe_next && st_next != bcd_pkg::ST_NO_SYNC)
            begin
                pend_go = pend_reg;
                pend_next = 1'b1;
                pw_next = {st_next, ei_next, od_next, ob_next};
            end
            if (state_next == S_IDLE && pend_next)
            begin
                pend_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            cur_reg    <= '0;
            cnt_reg    <= '0;
            newest_reg <= LASTE;
            oldest_reg <= '0;
            any_reg    <= 1'b0;
            pend_reg   <= 1'b0;
            strobe     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cur_reg    <= cur_next;
            cnt_reg    <= cnt_next;
            newest_reg <= newest_next;
            oldest_reg <= oldest_next;
            any_reg    <= any_next;
            pend_reg   <= pend_next;
            if (op_reg == bcd_pkg::OP_SYNC && state_reg != S_IDLE &&
                state_reg != S_CLEAR && st_next != bcd_pkg::ST_NO_SYNC)
            begin
                strobe <= pend_go || (pend_reg && state_next == S_IDLE) ||
                          (strobe_next && state_next == S_IDLE && !pend_reg);
            end
            else
            begin
                strobe <= strobe_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            op_reg  <= opcode;
            dev_reg <= device;
            blk_reg <= block_number;
            idx_reg <= buffer_index;
        end
        if (state_reg == S_SCHK || state_reg == S_EACT)
        begin
            mv_new_reg <= new_q;
            mv_old_reg <= old_q;
        end
        nxt_reg <= nxt_next;
        pw_reg  <= pw_next;
        if (op_reg == bcd_pkg::OP_SYNC && st_next != bcd_pkg::ST_NO_SYNC &&
            state_reg != S_IDLE && state_reg != S_CLEAR)
        begin
            // Emit the previously held word; last when the walk ends here
            if (pend_go || (pend_reg && state_next == S_IDLE))
            begin
                {status, entry_index, out_device, out_block} <= pw_reg;
                last <= (state_next == S_IDLE) && !(strobe_next && pend_reg);
            end
            else
            begin
                {status, entry_index, out_device, out_block} <=
                    {st_next, ei_next, od_next, ob_next};
                last <= 1'b1;
            end
            was_hit    <= 1'b0;
            needs_fill <= 1'b0;
        end
        else
        begin
            status      <= st_next;
            entry_index <= ei_next;
            was_hit     <= hit_next;
            needs_fill  <= fill_next;
            out_device  <= od_next;
            out_block   <= ob_next;
            last        <= last_next;
        end
    end

endmodule

// File: src/bcd_checker.sv
module bcd_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic strobe,
    input logic last,
    input logic was_hit,
    input logic needs_fill
);
    // A command taken raises busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise");

    // No result while idle
    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(!busy) && !busy) |-> !strobe)
        else $error("stray result");

    // A hit always comes as a single final word
    a_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && was_hit) |-> last)
        else $error("hit not last");

    // The fill flag stays low while strobe is low
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (!strobe) |-> !needs_fill)
        else $error("fill flag");

endmodule

bind block_cache_directory_lru_unit bcd_checker u_bcd_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .strobe(strobe),
    .last(last), .was_hit(was_hit), .needs_fill(needs_fill)
);
